// ===== hw/rtl/tvmp_pkg.sv =====
// Shared types, constants and codes for the tag=value message parser.
// Used by every module of the block; depends on nothing.
package tvmp_pkg;

	localparam int TAG_LIMIT_DEF = 1024;
	localparam int MAX_SCALE_DEF = 15;
	localparam int TBL_MAX_DEPTH = 1024;
	localparam int TBL_INDEX_W   = 10;
	localparam int TAG_W         = 16;
	localparam int MAG_W         = 63;
	localparam int PLEN_W        = 16;
	localparam int OFF_W         = 32;

	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	localparam logic [7:0] CH_SOH   = 8'h01;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_Y_UP  = 8'h59;
	localparam logic [7:0] CH_Y_LO  = 8'h79;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	localparam logic REQ_BYTE  = 1'b0;
	localparam logic REQ_TABLE = 1'b1;

	localparam logic [2:0] KIND_INT      = 3'd0;
	localparam logic [2:0] KIND_DEC      = 3'd1;
	localparam logic [2:0] KIND_BOOL     = 3'd2;
	localparam logic [2:0] KIND_STR_BYTE = 3'd3;
	localparam logic [2:0] KIND_STR_END  = 3'd4;
	localparam logic [2:0] KIND_DONE     = 3'd5;
	localparam logic [2:0] KIND_ERROR    = 3'd6;

	localparam logic [2:0] ERR_BAD_TAG  = 3'd0;
	localparam logic [2:0] ERR_NUM_END  = 3'd1;
	localparam logic [2:0] ERR_CSTR_END = 3'd2;
	localparam logic [2:0] ERR_UNTERM   = 3'd3;
	localparam logic [2:0] ERR_BOOL_END = 3'd4;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_INT_START,
		PH_INT,
		PH_FRAC,
		PH_BOOL,
		PH_BOOL_END,
		PH_STR,
		PH_CSTR
	} phase_e;

	typedef struct packed {
		logic                   req_type;
		logic [7:0]             data_byte;
		logic                   last_byte;
		logic [TBL_INDEX_W-1:0] table_index;
		logic [2:0]             table_class;
	} req_t;

	typedef struct packed {
		logic [2:0]        kind;
		logic [TAG_W-1:0]  tag;
		logic signed [63:0] int_value;
		logic [3:0]        scale;
		logic              bool_value;
		logic [7:0]        value_byte;
		logic [2:0]        error_code;
		logic [OFF_W-1:0]  error_offset;
		logic              last;
	} res_t;

	typedef struct packed {
		res_t r0;
		res_t r1;
		logic two;
	} res_pair_t;

	typedef struct packed {
		logic                   wr_en;
		logic [TBL_INDEX_W-1:0] wr_index;
		logic [2:0]             wr_class;
		logic [TAG_W-1:0]       rd_tag;
	} tbl_req_t;

	typedef struct packed {
		logic       busy;
		logic [2:0] cls;
	} tbl_rsp_t;

endpackage

// ===== hw/rtl/tvmp_class_mem.sv =====
// Tag class table: one write and one registered read per cycle, cleared after reset.
// Depends on tvmp_pkg.
module tvmp_class_mem #(
	parameter int TAG_LIMIT = tvmp_pkg::TAG_LIMIT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tvmp_pkg::tbl_req_t tbl_req,
	output tvmp_pkg::tbl_rsp_t tbl_rsp
);

	localparam int DEPTH = (TAG_LIMIT < tvmp_pkg::TBL_MAX_DEPTH) ? TAG_LIMIT :
		tvmp_pkg::TBL_MAX_DEPTH;
	localparam int AW = $clog2(DEPTH);

	logic [2:0]    mem [DEPTH];
	logic          busy_q;
	logic [AW-1:0] clr_q;
	logic [2:0]    cls_q;
	logic          inr_q;

	logic          wr_ok;
	logic          rd_ok;
	logic          we;
	logic [AW-1:0] wa;
	logic [2:0]    wd;
	logic [AW-1:0] ra;

	assign wr_ok = tbl_req.wr_en && (32'(tbl_req.wr_index) < 32'(DEPTH));
	assign rd_ok = 32'(tbl_req.rd_tag) < 32'(DEPTH);
	assign we    = busy_q || wr_ok;
	assign wa    = busy_q ? clr_q : tbl_req.wr_index[AW-1:0];
	assign wd    = busy_q ? 3'b000 : tbl_req.wr_class;
	assign ra    = tbl_req.rd_tag[AW-1:0];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		cls_q <= (we && (wa == ra)) ? wd : mem[ra];
		inr_q <= rd_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tbl_rsp.busy = busy_q;
	assign tbl_rsp.cls  = inr_q ? cls_q : 3'b000;

endmodule

// ===== hw/rtl/tvmp_parser.sv =====
// Input register, parse state and per-byte result logic of the message parser.
// Depends on tvmp_pkg; talks to tvmp_class_mem and tvmp_out_buf.
module tvmp_parser #(
	parameter int MAX_SCALE = tvmp_pkg::MAX_SCALE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  tvmp_pkg::req_t      req_data,
	output tvmp_pkg::tbl_req_t  tbl_req,
	input  tvmp_pkg::tbl_rsp_t  tbl_rsp,
	output logic                pair_valid,
	output tvmp_pkg::res_pair_t pair,
	input  logic                pair_room
);

	localparam int FW = $clog2(MAX_SCALE + 1);
	localparam int TW = tvmp_pkg::TAG_W;
	localparam int MW = tvmp_pkg::MAG_W;
	localparam int PW = tvmp_pkg::PLEN_W;
	localparam int OW = tvmp_pkg::OFF_W;

	logic            valid_s1;
	tvmp_pkg::req_t  req_s1;

	tvmp_pkg::phase_e ph_q, ph_n;
	logic [TW-1:0]   tag_q, tag_n;
	logic            ts_q, ts_n;
	logic [MW-1:0]   mag_q, mag_n;
	logic            neg_q, neg_n;
	logic [FW-1:0]   frac_q, frac_n;
	logic            plv_q, plv_n;
	logic [PW-1:0]   pl_q, pl_n;
	logic [PW-1:0]   rem_q, rem_n;
	logic [OW-1:0]   off_q, off_n;
	logic            bh_q, bh_n;
	logic            drop_q, drop_n;

	logic [7:0]      b;
	logic [3:0]      dig;
	logic            is_digit;
	logic [MW+3:0]   mag_x;
	logic [MW-1:0]   mag_dig;
	logic [TW+3:0]   tag_x;
	logic [TW-1:0]   tag_dig;
	logic [63:0]     mag_ext;
	logic [63:0]     sval;
	logic [PW-1:0]   plen_sat;
	logic [2:0]      cls;

	logic            fdone;
	logic            fail_v;
	logic [2:0]      fcode;
	tvmp_pkg::res_t  rs, re, r0;
	logic            rs_v, re_v;
	logic            need_room;
	logic            advance;
	logic            accept;

	function automatic logic [2:0] end_code(tvmp_pkg::phase_e ph);
		logic [2:0] c;
		case (ph)
			tvmp_pkg::PH_TAG:      c = tvmp_pkg::ERR_BAD_TAG;
			tvmp_pkg::PH_CSTR:     c = tvmp_pkg::ERR_CSTR_END;
			tvmp_pkg::PH_STR:      c = tvmp_pkg::ERR_UNTERM;
			tvmp_pkg::PH_BOOL:     c = tvmp_pkg::ERR_BOOL_END;
			tvmp_pkg::PH_BOOL_END: c = tvmp_pkg::ERR_BOOL_END;
			default:               c = tvmp_pkg::ERR_NUM_END;
		endcase
		return c;
	endfunction

	assign b        = req_s1.data_byte;
	assign dig      = b[3:0];
	assign is_digit = (b >= tvmp_pkg::CH_0) && (b <= tvmp_pkg::CH_9);
	assign cls      = tbl_rsp.cls;

	// x10 + digit with saturation
	assign mag_x   = ({4'b0000, mag_q} << 3) + ({4'b0000, mag_q} << 1) + (MW+4)'(dig);
	assign mag_dig = (|mag_x[MW+3:MW]) ? tvmp_pkg::MAG_MAX : mag_x[MW-1:0];
	assign tag_x   = ({4'b0000, tag_q} << 3) + ({4'b0000, tag_q} << 1) + (TW+4)'(dig);
	assign tag_dig = (|tag_x[TW+3:TW]) ? {TW{1'b1}} : tag_x[TW-1:0];

	assign mag_ext  = {1'b0, mag_q};
	assign sval     = neg_q ? (64'd0 - mag_ext) : mag_ext;
	assign plen_sat = (|mag_q[MW-1:PW]) ? {PW{1'b1}} : mag_q[PW-1:0];

	always_comb begin
		ph_n   = ph_q;
		tag_n  = tag_q;
		ts_n   = ts_q;
		mag_n  = mag_q;
		neg_n  = neg_q;
		frac_n = frac_q;
		plv_n  = plv_q;
		pl_n   = pl_q;
		rem_n  = rem_q;
		off_n  = off_q;
		bh_n   = bh_q;
		drop_n = drop_q;
		fdone  = 1'b0;
		fail_v = 1'b0;
		fcode  = tvmp_pkg::ERR_BAD_TAG;
		rs     = '0;
		rs_v   = 1'b0;
		re     = '0;
		re_v   = 1'b0;

		if (valid_s1 && (req_s1.req_type == tvmp_pkg::REQ_BYTE)) begin
			if (!drop_q) begin
				case (ph_q)
					tvmp_pkg::PH_TAG: begin
						if (is_digit) begin
							tag_n = tag_dig;
							ts_n  = 1'b1;
						end else if (b == tvmp_pkg::CH_EQ) begin
							mag_n  = '0;
							neg_n  = 1'b0;
							frac_n = '0;
							if (cls[0]) begin
								ph_n = tvmp_pkg::PH_INT_START;
							end else if (cls[1]) begin
								ph_n = tvmp_pkg::PH_BOOL;
							end else if (plv_q) begin
								ph_n  = tvmp_pkg::PH_CSTR;
								rem_n = pl_q;
								plv_n = 1'b0;
							end else begin
								ph_n = tvmp_pkg::PH_STR;
							end
						end else begin
							fail_v = 1'b1;
							fcode  = tvmp_pkg::ERR_BAD_TAG;
						end
					end
					tvmp_pkg::PH_INT_START, tvmp_pkg::PH_INT, tvmp_pkg::PH_FRAC: begin
						if ((ph_q == tvmp_pkg::PH_INT_START) && (b == tvmp_pkg::CH_MINUS)) begin
							neg_n = 1'b1;
							ph_n  = tvmp_pkg::PH_INT;
						end else if (is_digit) begin
							if (ph_q != tvmp_pkg::PH_FRAC) begin
								mag_n = mag_dig;
								ph_n  = tvmp_pkg::PH_INT;
							end else if (frac_q < FW'(MAX_SCALE)) begin
								mag_n  = mag_dig;
								frac_n = frac_q + FW'(1);
							end
						end else if ((b == tvmp_pkg::CH_DOT) && (ph_q != tvmp_pkg::PH_FRAC)) begin
							ph_n = tvmp_pkg::PH_FRAC;
						end else if (b == tvmp_pkg::CH_SOH) begin
							fdone = 1'b1;
							if (cls[2]) begin
								if (ph_q != tvmp_pkg::PH_FRAC) begin
									plv_n = 1'b1;
									pl_n  = plen_sat;
								end
							end else begin
								rs_v         = 1'b1;
								rs.tag       = tag_q;
								rs.int_value = $signed(sval);
								if (ph_q == tvmp_pkg::PH_FRAC) begin
									rs.kind  = tvmp_pkg::KIND_DEC;
									rs.scale = 4'(frac_q);
								end else begin
									rs.kind = tvmp_pkg::KIND_INT;
								end
							end
						end else begin
							fail_v = 1'b1;
							fcode  = tvmp_pkg::ERR_NUM_END;
						end
					end
					tvmp_pkg::PH_BOOL: begin
						bh_n = (b == tvmp_pkg::CH_Y_UP) || (b == tvmp_pkg::CH_Y_LO);
						ph_n = tvmp_pkg::PH_BOOL_END;
					end
					tvmp_pkg::PH_BOOL_END: begin
						if (b == tvmp_pkg::CH_SOH) begin
							rs_v          = 1'b1;
							rs.kind       = tvmp_pkg::KIND_BOOL;
							rs.tag        = tag_q;
							rs.bool_value = bh_q;
							fdone         = 1'b1;
						end else begin
							fail_v = 1'b1;
							fcode  = tvmp_pkg::ERR_BOOL_END;
						end
					end
					tvmp_pkg::PH_STR: begin
						rs_v   = 1'b1;
						rs.tag = tag_q;
						if (b == tvmp_pkg::CH_SOH) begin
							rs.kind = tvmp_pkg::KIND_STR_END;
							fdone   = 1'b1;
						end else begin
							rs.kind       = tvmp_pkg::KIND_STR_BYTE;
							rs.value_byte = b;
						end
					end
					default: begin
						if (rem_q != '0) begin
							rs_v          = 1'b1;
							rs.kind       = tvmp_pkg::KIND_STR_BYTE;
							rs.tag        = tag_q;
							rs.value_byte = b;
							rem_n         = rem_q - PW'(1);
						end else if (b == tvmp_pkg::CH_SOH) begin
							rs_v    = 1'b1;
							rs.kind = tvmp_pkg::KIND_STR_END;
							rs.tag  = tag_q;
							fdone   = 1'b1;
						end else begin
							fail_v = 1'b1;
							fcode  = tvmp_pkg::ERR_CSTR_END;
						end
					end
				endcase
			end

			if (fdone) begin
				ph_n   = tvmp_pkg::PH_TAG;
				tag_n  = '0;
				ts_n   = 1'b0;
				mag_n  = '0;
				neg_n  = 1'b0;
				frac_n = '0;
			end
			if (fail_v) begin
				rs_v            = 1'b1;
				rs.kind         = tvmp_pkg::KIND_ERROR;
				rs.error_code   = fcode;
				rs.error_offset = off_q;
				drop_n          = 1'b1;
			end

			if (req_s1.last_byte) begin
				if (!drop_n) begin
					re_v    = 1'b1;
					re.last = 1'b1;
					if ((ph_n == tvmp_pkg::PH_TAG) && !ts_n) begin
						re.kind = tvmp_pkg::KIND_DONE;
					end else begin
						re.kind         = tvmp_pkg::KIND_ERROR;
						re.error_code   = end_code(ph_n);
						re.error_offset = off_q + OW'(1);
					end
				end
				ph_n   = tvmp_pkg::PH_TAG;
				tag_n  = '0;
				ts_n   = 1'b0;
				mag_n  = '0;
				neg_n  = 1'b0;
				frac_n = '0;
				plv_n  = 1'b0;
				pl_n   = '0;
				rem_n  = '0;
				off_n  = '0;
				bh_n   = 1'b0;
				drop_n = 1'b0;
			end else begin
				off_n = off_q + OW'(1);
			end
		end
	end

	always_comb begin
		r0      = rs_v ? rs : re;
		r0.last = !(rs_v && re_v);
	end

	assign need_room  = rs_v || re_v;
	assign advance    = valid_s1 && (!need_room || pair_room);
	assign req_stall  = tbl_rsp.busy || (valid_s1 && !advance);
	assign accept     = req_valid && !req_stall;

	assign pair_valid = advance && need_room;
	assign pair.r0    = r0;
	assign pair.r1    = re;
	assign pair.two   = rs_v && re_v;

	assign tbl_req.wr_en    = advance && (req_s1.req_type == tvmp_pkg::REQ_TABLE);
	assign tbl_req.wr_index = req_s1.table_index;
	assign tbl_req.wr_class = req_s1.table_class;
	assign tbl_req.rd_tag   = advance ? tag_n : tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= tvmp_pkg::PH_TAG;
			tag_q  <= '0;
			ts_q   <= 1'b0;
			mag_q  <= '0;
			neg_q  <= 1'b0;
			frac_q <= '0;
			plv_q  <= 1'b0;
			pl_q   <= '0;
			rem_q  <= '0;
			off_q  <= '0;
			bh_q   <= 1'b0;
			drop_q <= 1'b0;
		end else if (advance) begin
			ph_q   <= ph_n;
			tag_q  <= tag_n;
			ts_q   <= ts_n;
			mag_q  <= mag_n;
			neg_q  <= neg_n;
			frac_q <= frac_n;
			plv_q  <= plv_n;
			pl_q   <= pl_n;
			rem_q  <= rem_n;
			off_q  <= off_n;
			bh_q   <= bh_n;
			drop_q <= drop_n;
		end
	end

endmodule

// ===== hw/rtl/tvmp_out_buf.sv =====
// Result register holding the one or two results of a request, shown in order.
// Depends on tvmp_pkg.
module tvmp_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pair_valid,
	input  tvmp_pkg::res_pair_t pair,
	output logic                pair_room,
	output logic                res_valid,
	input  logic                res_stall,
	output tvmp_pkg::res_t      res_data
);

	logic           valid_q;
	logic           two_q;
	logic           sec_q;
	tvmp_pkg::res_t r0_q;
	tvmp_pkg::res_t r1_q;
	logic           take;
	logic           drained;

	assign res_valid = valid_q;
	assign res_data  = sec_q ? r1_q : r0_q;
	assign take      = valid_q && !res_stall;
	assign drained   = take && (!two_q || sec_q);
	assign pair_room = !valid_q || drained;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			two_q   <= 1'b0;
			sec_q   <= 1'b0;
		end else if (pair_valid) begin
			valid_q <= 1'b1;
			two_q   <= pair.two;
			sec_q   <= 1'b0;
		end else if (drained) begin
			valid_q <= 1'b0;
			sec_q   <= 1'b0;
		end else if (take) begin
			sec_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pair_valid) begin
			r0_q <= pair.r0;
			r1_q <= pair.r1;
		end
	end

endmodule

// ===== hw/rtl/tag_value_message_parser_top.sv =====
// Tag=value message parser: one byte per request, typed field results out.
// Request channel takes message bytes and class table writes (req_type selects).
// Each request sits in an input register, is parsed by the parse logic against
// the tag class table, and its results land in the result register.
// Throughput: one request per cycle while each yields at most one result and
// res_stall is low; the last byte of a buffer may yield two results, which
// leave one per cycle while res_stall is low.
// Table writes and dropped bytes yield no result and never wait on the output.
// The class table is a single-port-write memory read once per cycle at the
// tag being assembled, so the class is ready when '=' arrives.
// Reset: a clearing pass zeroes the min(TAG_LIMIT, 1024) table entries (1024 by
// default), one entry per cycle; req_stall is high meanwhile.
// When the receiver holds res_stall, the shown result stays; requests that yield
// no result keep flowing, the first one that yields a result waits in the input
// register and req_stall rises.
// Depends on tvmp_pkg, tvmp_class_mem, tvmp_parser and tvmp_out_buf.
module tag_value_message_parser_top #(
	parameter int TAG_LIMIT = tvmp_pkg::TAG_LIMIT_DEF,
	parameter int MAX_SCALE = tvmp_pkg::MAX_SCALE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tvmp_pkg::req_t req_data,
	output logic           res_valid,
	input  logic           res_stall,
	output tvmp_pkg::res_t res_data
);

	tvmp_pkg::tbl_req_t  tbl_req;
	tvmp_pkg::tbl_rsp_t  tbl_rsp;
	logic                pair_valid;
	tvmp_pkg::res_pair_t pair;
	logic                pair_room;

	tvmp_class_mem #(
		.TAG_LIMIT(TAG_LIMIT)
	) u_class_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.tbl_req(tbl_req),
		.tbl_rsp(tbl_rsp)
	);

	tvmp_parser #(
		.MAX_SCALE(MAX_SCALE)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.tbl_req   (tbl_req),
		.tbl_rsp   (tbl_rsp),
		.pair_valid(pair_valid),
		.pair      (pair),
		.pair_room (pair_room)
	);

	tvmp_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.pair_valid(pair_valid),
		.pair      (pair),
		.pair_room (pair_room),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== hw/rtl/tvmp_checker.sv =====
// Port-level checks for the tag=value message parser, bound to the top level.
// Depends on tvmp_pkg and tag_value_message_parser_top.
module tvmp_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_stall,
	input logic           res_valid,
	input logic           res_stall,
	input tvmp_pkg::res_t res_data
);

	// table clearing blocks requests right after reset
	a_clear_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> req_stall)
		else $error("request taken during table clearing");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("stalled result changed");

	// a result not marked last is followed by its partner
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_data.last |=> res_valid)
		else $error("second result of a request missing");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ((res_data.kind == tvmp_pkg::KIND_DONE) ||
		(res_data.kind == tvmp_pkg::KIND_ERROR)) |-> res_data.last && (res_data.tag == '0))
		else $error("done or error result not final or carries a tag");

endmodule

bind tag_value_message_parser_top tvmp_checker u_tvmp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_stall(req_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

// ===== dv/tag_value_message_parser_top_test.sv =====
// Testbench for tag_value_message_parser_top: streams FIX-style byte buffers and
// class table writes, predicts every typed result and checks it field by field.
// Depends on tvmp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tag_value_message_parser_top_test;
	import tvmp_pkg::*;

	localparam int ITEM_TARGET  = 1100;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 16;
	localparam int POOL_SIZE    = 12;

	localparam logic [2:0] CLS_INT  = 3'b001;
	localparam logic [2:0] CLS_BOOL = 3'b010;
	localparam logic [2:0] CLS_LEN  = 3'b100;

	localparam logic [7:0] SOH_MARK = 8'h7C;
	localparam logic [7:0] CH_N_UP  = 8'h4E;

	logic clk;
	logic arst_n;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	tag_value_message_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// parser shadow state
	logic [2:0]  cls_tbl [TBL_MAX_DEPTH];
	phase_e      p_phase;
	logic [15:0] p_tag;
	logic [62:0] p_mag;
	logic        p_neg;
	logic [3:0]  p_frac;
	logic        p_len_ok;
	logic [15:0] p_len;
	logic [15:0] p_left;
	logic [31:0] p_off;
	logic        p_tag_seen;
	logic        p_bool;
	logic        p_drop;

	res_t step_q[$];
	res_t want_q[$];

	logic [7:0] msg_bytes[$];
	int         pend_len;
	int         tag_pool[POOL_SIZE];

	bit src_gaps = 1'b0;
	bit sink_gaps = 1'b0;
	bit hold_off_req = 1'b0;

	int n_reqs = 0;
	int n_bytes = 0;
	int n_bufs = 0;
	int n_results = 0;
	int mismatch_cnt = 0;
	int kind_cnt[8];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic res_t mk_res(logic [2:0] kind, logic [15:0] tg, logic [63:0] iv,
			logic [3:0] sc, logic bv, logic [7:0] vb, logic [2:0] ec, logic [31:0] eo);
		res_t x;
		x = '0;
		x.kind = kind;
		x.tag = tg;
		x.int_value = iv;
		x.scale = sc;
		x.bool_value = bv;
		x.value_byte = vb;
		x.error_code = ec;
		x.error_offset = eo;
		return x;
	endfunction

	function automatic logic [2:0] class_of_tag(logic [15:0] t);
		return (t < TAG_LIMIT_DEF) ? cls_tbl[t[TBL_INDEX_W-1:0]] : 3'd0;
	endfunction

	function automatic logic [62:0] push_digit(logic [62:0] m, logic [3:0] d);
		logic [63:0] lim;
		lim = ({1'b0, MAG_MAX} - 64'(d)) / 64'd10;
		if ({1'b0, m} > lim)
			return MAG_MAX;
		return m * 63'd10 + 63'(d);
	endfunction

	function automatic void clear_field();
		p_phase = PH_TAG;
		p_tag = '0;
		p_tag_seen = 1'b0;
		p_mag = '0;
		p_neg = 1'b0;
		p_frac = '0;
	endfunction

	function automatic void clear_buffer();
		clear_field();
		p_len_ok = 1'b0;
		p_len = '0;
		p_left = '0;
		p_off = '0;
		p_bool = 1'b0;
		p_drop = 1'b0;
	endfunction

	function automatic void raise_error(logic [2:0] code);
		step_q.push_back(mk_res(KIND_ERROR, '0, '0, '0, 1'b0, '0, code, p_off));
		p_drop = 1'b1;
	endfunction

	function automatic void close_number();
		logic [2:0]  c;
		logic [63:0] v;
		c = class_of_tag(p_tag);
		v = p_neg ? -{1'b0, p_mag} : {1'b0, p_mag};
		if (c[2]) begin
			if (p_phase != PH_FRAC) begin
				p_len_ok = 1'b1;
				p_len = (p_mag > 63'd65535) ? 16'hFFFF : p_mag[15:0];
			end
		end else if (p_phase == PH_FRAC) begin
			step_q.push_back(mk_res(KIND_DEC, p_tag, v, p_frac, 1'b0, '0, '0, '0));
		end else begin
			step_q.push_back(mk_res(KIND_INT, p_tag, v, '0, 1'b0, '0, '0, '0));
		end
		clear_field();
	endfunction

	function automatic logic [2:0] open_field_code();
		case (p_phase)
			PH_TAG:               return ERR_BAD_TAG;
			PH_CSTR:              return ERR_CSTR_END;
			PH_STR:               return ERR_UNTERM;
			PH_BOOL, PH_BOOL_END: return ERR_BOOL_END;
			default:              return ERR_NUM_END;
		endcase
	endfunction

	function automatic void predict_parse(req_t r);
		logic [7:0]  b;
		logic        is_dig;
		logic [2:0]  c;
		logic [31:0] t;
		step_q.delete();
		if (r.req_type == REQ_TABLE) begin
			cls_tbl[r.table_index] = r.table_class;
			return;
		end
		b = r.data_byte;
		is_dig = (b >= CH_0) && (b <= CH_9);
		if (!p_drop) begin
			case (p_phase)
				PH_TAG: begin
					if (is_dig) begin
						t = 32'(p_tag) * 32'd10 + 32'(b[3:0]);
						p_tag = (t > 32'd65535) ? 16'hFFFF : t[15:0];
						p_tag_seen = 1'b1;
					end else if (b == CH_EQ) begin
						c = class_of_tag(p_tag);
						p_mag = '0;
						p_neg = 1'b0;
						p_frac = '0;
						if (c[0])
							p_phase = PH_INT_START;
						else if (c[1])
							p_phase = PH_BOOL;
						else if (p_len_ok) begin
							p_phase = PH_CSTR;
							p_left = p_len;
							p_len_ok = 1'b0;
						end else
							p_phase = PH_STR;
					end else
						raise_error(ERR_BAD_TAG);
				end
				PH_INT_START, PH_INT: begin
					if (p_phase == PH_INT_START && b == CH_MINUS) begin
						p_neg = 1'b1;
						p_phase = PH_INT;
					end else if (is_dig) begin
						p_mag = push_digit(p_mag, b[3:0]);
						p_phase = PH_INT;
					end else if (b == CH_DOT)
						p_phase = PH_FRAC;
					else if (b == CH_SOH)
						close_number();
					else
						raise_error(ERR_NUM_END);
				end
				PH_FRAC: begin
					if (is_dig) begin
						if (p_frac < MAX_SCALE_DEF) begin
							p_mag = push_digit(p_mag, b[3:0]);
							p_frac++;
						end
					end else if (b == CH_SOH)
						close_number();
					else
						raise_error(ERR_NUM_END);
				end
				PH_BOOL: begin
					p_bool = (b == CH_Y_UP) || (b == CH_Y_LO);
					p_phase = PH_BOOL_END;
				end
				PH_BOOL_END: begin
					if (b == CH_SOH) begin
						step_q.push_back(mk_res(KIND_BOOL, p_tag, '0, '0, p_bool, '0, '0, '0));
						clear_field();
					end else
						raise_error(ERR_BOOL_END);
				end
				PH_STR: begin
					if (b == CH_SOH) begin
						step_q.push_back(mk_res(KIND_STR_END, p_tag, '0, '0, 1'b0, '0, '0, '0));
						clear_field();
					end else
						step_q.push_back(mk_res(KIND_STR_BYTE, p_tag, '0, '0, 1'b0, b, '0, '0));
				end
				default: begin
					if (p_left != 0) begin
						step_q.push_back(mk_res(KIND_STR_BYTE, p_tag, '0, '0, 1'b0, b, '0, '0));
						p_left--;
					end else if (b == CH_SOH) begin
						step_q.push_back(mk_res(KIND_STR_END, p_tag, '0, '0, 1'b0, '0, '0, '0));
						clear_field();
					end else
						raise_error(ERR_CSTR_END);
				end
			endcase
		end
		if (r.last_byte) begin
			if (!p_drop) begin
				if (p_phase == PH_TAG && !p_tag_seen)
					step_q.push_back(mk_res(KIND_DONE, '0, '0, '0, 1'b0, '0, '0, '0));
				else
					step_q.push_back(mk_res(KIND_ERROR, '0, '0, '0, 1'b0, '0,
						open_field_code(), p_off + 32'd1));
			end
			clear_buffer();
		end else
			p_off++;
		if (step_q.size() != 0)
			step_q[$].last = 1'b1;
		foreach (step_q[i])
			want_q.push_back(step_q[i]);
	endfunction

	function automatic void cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatch_cnt++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		res_t w;
		if (arst_n && res_valid && !res_stall) begin
			n_results++;
			if (want_q.size() == 0) begin
				$error("unexpected result: kind %0d tag %0d", res_data.kind, res_data.tag);
				mismatch_cnt++;
			end else begin
				w = want_q.pop_front();
				kind_cnt[w.kind]++;
				cmp_field("kind", 64'(w.kind), 64'(res_data.kind));
				cmp_field("tag", 64'(w.tag), 64'(res_data.tag));
				cmp_field("int_value", w.int_value, res_data.int_value);
				cmp_field("scale", 64'(w.scale), 64'(res_data.scale));
				cmp_field("bool_value", 64'(w.bool_value), 64'(res_data.bool_value));
				cmp_field("value_byte", 64'(w.value_byte), 64'(res_data.value_byte));
				cmp_field("error_code", 64'(w.error_code), 64'(res_data.error_code));
				cmp_field("error_offset", 64'(w.error_offset), 64'(res_data.error_offset));
				cmp_field("last", 64'(w.last), 64'(res_data.last));
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on demand
	initial begin : res_stall_gen
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_off_req = 1'b0;
			end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
				res_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (res_valid && !res_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_req(req_t r);
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do
			@(posedge clk);
		while (req_stall);
		predict_parse(r);
		n_reqs++;
		if (r.req_type == REQ_BYTE)
			n_bytes++;
	endtask

	task automatic send_byte(logic [7:0] b, logic fin);
		req_t r;
		r.req_type = REQ_BYTE;
		r.data_byte = b;
		r.last_byte = fin;
		r.table_index = TBL_INDEX_W'($urandom_range(0, TBL_MAX_DEPTH - 1));
		r.table_class = 3'($urandom_range(0, 7));
		send_req(r);
	endtask

	task automatic set_class(logic [TBL_INDEX_W-1:0] idx, logic [2:0] cls);
		req_t r;
		r.req_type = REQ_TABLE;
		r.data_byte = 8'($urandom_range(0, 255));
		r.last_byte = 1'($urandom_range(0, 1));
		r.table_index = idx;
		r.table_class = cls;
		send_req(r);
	endtask

	// '|' stands for SOH
	task automatic send_text(string s, bit fin);
		logic [7:0] b;
		for (int i = 0; i < s.len(); i++) begin
			b = (s[i] == SOH_MARK) ? CH_SOH : s[i];
			send_byte(b, fin && (i == s.len() - 1));
		end
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		do
			@(posedge clk);
		while (want_q.size() != 0);
	endtask

	task automatic push_digits(int nd);
		repeat (nd) msg_bytes.push_back(CH_0 + 8'($urandom_range(0, 9)));
	endtask

	task automatic build_field();
		int         tg;
		int         nd;
		int         d;
		int         lval;
		int         pick;
		logic [2:0] c;
		logic [7:0] b;
		string      ts;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			tg = 0;
			ts = "";
		end else begin
			tg = (pick < 12) ? $urandom_range(1024, 99999) : tag_pool[$urandom_range(0, POOL_SIZE - 1)];
			ts = $sformatf("%0d", tg);
		end
		c = (tg < TAG_LIMIT_DEF) ? cls_tbl[TBL_INDEX_W'(tg)] : 3'd0;
		for (int i = 0; i < ts.len(); i++)
			msg_bytes.push_back(ts[i]);
		msg_bytes.push_back(CH_EQ);
		if (c[0]) begin
			if ($urandom_range(0, 2) == 0)
				msg_bytes.push_back(CH_MINUS);
			if (c[2])
				nd = $urandom_range(0, 1);
			else
				nd = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 22) : $urandom_range(0, 6);
			lval = 0;
			repeat (nd) begin
				d = $urandom_range(0, 9);
				msg_bytes.push_back(CH_0 + 8'(d));
				lval = lval * 10 + d;
			end
			if ($urandom_range(0, 99) < (c[2] ? 5 : 35)) begin
				msg_bytes.push_back(CH_DOT);
				push_digits(($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 4));
			end else if (c[2])
				pend_len = lval;
		end else if (c[1]) begin
			case ($urandom_range(0, 4))
				0:       msg_bytes.push_back(CH_Y_UP);
				1:       msg_bytes.push_back(CH_Y_LO);
				2:       msg_bytes.push_back(CH_N_UP);
				3:       msg_bytes.push_back(CH_SOH);
				default: msg_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end else if (pend_len >= 0) begin
			repeat (pend_len) msg_bytes.push_back(8'($urandom_range(0, 255)));
			pend_len = -1;
		end else begin
			repeat ($urandom_range(0, 6)) begin
				b = 8'($urandom_range(0, 254));
				msg_bytes.push_back((b == CH_SOH) ? 8'hFF : b);
			end
		end
		msg_bytes.push_back(CH_SOH);
	endtask

	// mostly well-formed buffers; some get a corrupted byte or end early
	task automatic send_random_buffer();
		int nf;
		int cut;
		int pick;
		msg_bytes.delete();
		pend_len = -1;
		nf = $urandom_range(1, 5);
		repeat (nf) build_field();
		cut = msg_bytes.size() - 1;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
		else if (pick < 18)
			cut = $urandom_range(0, msg_bytes.size() - 1);
		for (int k = 0; k <= cut; k++) begin
			if ($urandom_range(0, 63) == 0)
				set_class(TBL_INDEX_W'($urandom_range(0, TBL_MAX_DEPTH - 1)), 3'($urandom_range(0, 7)));
			send_byte(msg_bytes[k], k == cut);
		end
		n_bufs++;
	endtask

	task automatic test_directed();
		src_gaps = 1'b1;
		sink_gaps = 1'b1;
		set_class(10'd34, CLS_INT);
		set_class(10'd44, CLS_INT);
		set_class(10'd43, CLS_BOOL);
		set_class(10'd9, CLS_INT | CLS_LEN);
		set_class(10'd7, CLS_LEN);
		set_class(10'd3, CLS_INT | CLS_BOOL);
		set_class(10'd6, CLS_BOOL | CLS_LEN);
		set_class(10'd1023, CLS_INT | CLS_BOOL | CLS_LEN);
		send_text("34=-12|44=3.14|44=5.|34=|34=-|", 1'b1);
		send_text("34=99999999999999999999|34=-9223372036854775808|", 1'b1);
		send_text("44=1.12345678901234567|43=Y|43=y|43=n|43=||6=Y|", 1'b1);
		send_text("=ab|99999=x|7=q|1023=2|12=a||", 1'b1);
		send_text("9=-3|5=x|y|9=1.5|5=ab|3=7|", 1'b1);
		send_text("5=", 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_SOH, 1'b1);
		set_class(10'd0, CLS_INT);
		send_text("=-7|", 1'b1);
		set_class(10'd0, 3'd0);
		// errors mid-buffer, rest of the buffer dropped
		send_text("3a=5|", 1'b1);
		send_text("34=1x|", 1'b1);
		send_text("34=1-|", 1'b1);
		send_text("44=1.2.|", 1'b1);
		send_text("9=1|5=ab|", 1'b1);
		send_text("43=YY|", 1'b1);
		send_text("|", 1'b1);
		// buffer ends inside a field
		send_text("12", 1'b1);
		send_text("34=5", 1'b1);
		send_text("44=5.2", 1'b1);
		send_text("43=", 1'b1);
		send_text("43=Y", 1'b1);
		send_text("5=ab", 1'b1);
		send_text("9=70000|5=ab", 1'b1);
		send_text("=", 1'b1);
	endtask

	task automatic test_backpressure();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		drain_results();
		hold_off_req = 1'b1;
		send_text("5=", 1'b0);
		repeat (60) send_byte(8'($urandom_range(2, 255)), 1'b0);
		send_byte(CH_SOH, 1'b1);
		drain_results();
	endtask

	task automatic test_random_messages();
		for (int i = 0; i < POOL_SIZE; i++) begin
			tag_pool[i] = (i == 0) ? 1023 : $urandom_range(1, 1022);
			set_class(TBL_INDEX_W'(tag_pool[i]), (i < 8) ? 3'(i) : 3'(i - 4));
		end
		while (n_bytes < ITEM_TARGET - 100) begin
			if (n_bufs % 8 == 0) begin
				src_gaps = ($urandom_range(0, 2) != 0);
				sink_gaps = ($urandom_range(0, 2) != 0);
			end
			send_random_buffer();
		end
	endtask

	task automatic test_clean_tail();
		src_gaps = 1'b0;
		sink_gaps = 1'b0;
		while (n_bytes < ITEM_TARGET)
			send_random_buffer();
	endtask

	initial begin : main
		foreach (cls_tbl[i])
			cls_tbl[i] = 3'd0;
		clear_buffer();
		foreach (kind_cnt[i])
			kind_cnt[i] = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random_messages();
		test_clean_tail();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("summary: %0d requests (%0d bytes, %0d buffers), %0d results checked",
			n_reqs, n_bytes, n_bufs, n_results);
		$display("summary: int %0d dec %0d bool %0d str byte %0d str end %0d done %0d error %0d",
			kind_cnt[KIND_INT], kind_cnt[KIND_DEC], kind_cnt[KIND_BOOL], kind_cnt[KIND_STR_BYTE],
			kind_cnt[KIND_STR_END], kind_cnt[KIND_DONE], kind_cnt[KIND_ERROR]);
		if (mismatch_cnt == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
